[sv/fbpw_pkg.sv]
package fbpw_pkg;

    localparam int unsigned COORD_W   = 16;
    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned SHIFT_W   = 5;
    localparam int unsigned FIELD_W   = 48;
    localparam int unsigned OFFSET_W  = 2 * COORD_W + 1;
    localparam int unsigned FMT_W     = 2;
    localparam int unsigned INDEX_W   = 3;
    localparam int unsigned CFG_W     = 48;
    localparam int unsigned IN_DATA_W = 2 * COORD_W + 3 * CHAN_W;
    localparam int unsigned OUT_DATA_W = FIELD_W + WORD_W;

    localparam int unsigned ADDR_BITS_DEFAULT = 48;

    localparam logic [FMT_W-1:0] FMT_RGB  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_BGR  = 2'd1;
    localparam logic [FMT_W-1:0] FMT_MASK = 2'd2;

    localparam logic [INDEX_W-1:0] REG_PIXEL_FORMAT  = 3'd0;
    localparam logic [INDEX_W-1:0] REG_RED_MASK      = 3'd1;
    localparam logic [INDEX_W-1:0] REG_GREEN_MASK    = 3'd2;
    localparam logic [INDEX_W-1:0] REG_BLUE_MASK     = 3'd3;
    localparam logic [INDEX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
    localparam logic [INDEX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;
    localparam logic [INDEX_W-1:0] REG_LINE_PITCH    = 3'd6;
    localparam logic [INDEX_W-1:0] REG_FRAME_BASE    = 3'd7;

    typedef struct packed {
        logic [FMT_W-1:0]   pixel_format;
        logic [WORD_W-1:0]  red_mask;
        logic [WORD_W-1:0]  green_mask;
        logic [WORD_W-1:0]  blue_mask;
        logic [SHIFT_W-1:0] red_shift;
        logic [SHIFT_W-1:0] green_shift;
        logic [SHIFT_W-1:0] blue_shift;
        logic [COORD_W-1:0] screen_width;
        logic [COORD_W-1:0] screen_height;
        logic [COORD_W-1:0] line_pitch;
        logic [FIELD_W-1:0] frame_base;
    } cfg_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  red;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_x;
    } pixel_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [WORD_W-1:0]   pixel_word;
    } mid_t;

    typedef struct packed {
        logic [WORD_W-1:0]  pixel_word;
        logic [FIELD_W-1:0] write_address;
    } result_t;

    function automatic logic [WORD_W-1:0] place_channel(
        input logic [CHAN_W-1:0]  value,
        input logic [SHIFT_W-1:0] shift,
        input logic [WORD_W-1:0]  mask
    );
        logic [WORD_W-1:0] wide;
        wide = {{(WORD_W - CHAN_W){1'b0}}, value};
        return (wide << shift) & mask;
    endfunction

endpackage

[sv/fbpw_cfg.sv]
module fbpw_cfg
    import fbpw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    function automatic logic [SHIFT_W-1:0] low_set_bit(input logic [WORD_W-1:0] m);
        logic [SHIFT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                pos = SHIFT_W'(i);
            end
        end
        return pos;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PIXEL_FORMAT:
                begin
                    cfg_next.pixel_format = cfg_data[FMT_W-1:0];
                end
                REG_RED_MASK:
                begin
                    cfg_next.red_mask  = cfg_data[WORD_W-1:0];
                    cfg_next.red_shift = low_set_bit(cfg_data[WORD_W-1:0]);
                end
                REG_GREEN_MASK:
                begin
                    cfg_next.green_mask  = cfg_data[WORD_W-1:0];
                    cfg_next.green_shift = low_set_bit(cfg_data[WORD_W-1:0]);
                end
                REG_BLUE_MASK:
                begin
                    cfg_next.blue_mask  = cfg_data[WORD_W-1:0];
                    cfg_next.blue_shift = low_set_bit(cfg_data[WORD_W-1:0]);
                end
                REG_SCREEN_WIDTH:
                begin
                    cfg_next.screen_width = cfg_data[COORD_W-1:0];
                end
                REG_SCREEN_HEIGHT:
                begin
                    cfg_next.screen_height = cfg_data[COORD_W-1:0];
                end
                REG_LINE_PITCH:
                begin
                    cfg_next.line_pitch = cfg_data[COORD_W-1:0];
                end
                REG_FRAME_BASE:
                begin
                    cfg_next.frame_base = cfg_data[FIELD_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[sv/fbpw_input.sv]
module fbpw_input
    import fbpw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [IN_DATA_W-1:0] in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pixel_t               out_pixel
);

    logic   valid_reg;
    logic   valid_next;
    pixel_t pixel_reg;
    logic   load;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_reg <= pixel_t'(in_data);
        end
    end

endmodule

[sv/fbpw_encode.sv]
module fbpw_encode
    import fbpw_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   in_valid,
    output logic   in_ready,
    input  pixel_t in_pixel,
    output logic   out_valid,
    input  logic   out_ready,
    output mid_t   out_mid
);

    logic                valid_reg;
    logic                valid_next;
    mid_t                mid_reg;
    mid_t                mid_next;
    logic                visible;
    logic                load;
    logic [2*COORD_W-1:0] row_start;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_mid   = mid_reg;

    assign visible = (in_pixel.pos_x < cfg.screen_width)
                  && (in_pixel.pos_y < cfg.screen_height);

    assign row_start = in_pixel.pos_y * cfg.line_pitch;

    always_comb
    begin
        mid_next.offset = OFFSET_W'(row_start) + OFFSET_W'(in_pixel.pos_x);
        case (cfg.pixel_format)
            FMT_BGR:
            begin
                mid_next.pixel_word = {{(WORD_W - 3 * CHAN_W){1'b0}},
                                       in_pixel.red, in_pixel.green, in_pixel.blue};
            end
            FMT_MASK:
            begin
                mid_next.pixel_word =
                    place_channel(in_pixel.red,   cfg.red_shift,   cfg.red_mask)
                  | place_channel(in_pixel.green, cfg.green_shift, cfg.green_mask)
                  | place_channel(in_pixel.blue,  cfg.blue_shift,  cfg.blue_mask);
            end
            default:
            begin
                mid_next.pixel_word = {{(WORD_W - 3 * CHAN_W){1'b0}},
                                       in_pixel.blue, in_pixel.green, in_pixel.red};
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid && visible;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mid_reg <= mid_next;
        end
    end

endmodule

[sv/fbpw_address.sv]
module fbpw_address
    import fbpw_pkg::*;
#(
    parameter int unsigned ADDR_BITS = ADDR_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mid_t                  in_mid,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    localparam logic [FIELD_W-1:0] ADDR_MASK =
        (ADDR_BITS >= FIELD_W) ? {FIELD_W{1'b1}}
                               : FIELD_W'((64'd1 << ADDR_BITS) - 64'd1);

    logic               valid_reg;
    logic               valid_next;
    result_t            result_reg;
    result_t            result_next;
    logic               load;
    logic [FIELD_W-1:0] byte_offset;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = OUT_DATA_W'(result_reg);

    assign byte_offset = FIELD_W'({in_mid.offset, 2'b00});

    always_comb
    begin
        result_next.write_address = (cfg.frame_base + byte_offset) & ADDR_MASK;
        result_next.pixel_word    = in_mid.pixel_word;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

endmodule

[sv/framebuffer_pixel_writer.sv]
// Framebuffer pixel writer.
// Input stream s_axis: one pixel write request per transaction (column, row,
// red, green, blue). Output stream m_axis: byte address and 32-bit pixel word
// of the framebuffer write. A request outside screen_width/screen_height
// gives no output transaction.
// Config channel cfg_*: register index and data; always ready, one register
// per transaction. Write it only while the pipeline is empty.
// A request accepted on s_axis passes the input, encode and result registers
// in turn to m_axis. Throughput: one request per clock while m_axis_tready
// is high; the y*pitch multiply sits in the encode stage and the base add in
// the result stage, each one register deep.
// Stall: each stage holds its transaction while the next is full and not
// taking; a stage that is empty or draining still accepts, so up to three
// requests are buffered while m_axis_tready is low.
// Reset: the configuration registers clear to zero, the pipeline empties, and
// every request is dropped until screen_width and screen_height are non-zero.
module framebuffer_pixel_writer
    import fbpw_pkg::*;
#(
    parameter int unsigned ADDR_BITS = ADDR_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pos_x, pos_y, red, green, blue
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // write_address, pixel_word
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [INDEX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    cfg_t   cfg;
    logic   pix_valid;
    logic   pix_ready;
    pixel_t pix;
    logic   mid_valid;
    logic   mid_ready;
    mid_t   mid;

    fbpw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fbpw_input u_input (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .out_valid (pix_valid),
        .out_ready (pix_ready),
        .out_pixel (pix)
    );

    fbpw_encode u_encode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (pix_valid),
        .in_ready  (pix_ready),
        .in_pixel  (pix),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_mid   (mid)
    );

    fbpw_address #(
        .ADDR_BITS (ADDR_BITS)
    ) u_address (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_mid    (mid),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

[dv/framebuffer_pixel_writer_tb.sv]
module framebuffer_pixel_writer_tb;
    import fbpw_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int RESET_CYCLES     = 12;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int RANDOM_PHASES    = 14;
    localparam int WRITES_PER_PHASE = 88;

    localparam logic [FMT_W-1:0] FMT_SPARE = 2'd3;

    class fb_write_tracker;
        logic [FMT_W-1:0]   fmt;
        logic [WORD_W-1:0]  red_mask;
        logic [WORD_W-1:0]  green_mask;
        logic [WORD_W-1:0]  blue_mask;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic [COORD_W-1:0] pitch;
        logic [FIELD_W-1:0] base;
        result_t            pending_writes[$];
        int                 errors;

        function new();
            fmt        = FMT_RGB;
            red_mask   = '0;
            green_mask = '0;
            blue_mask  = '0;
            width      = '0;
            height     = '0;
            pitch      = '0;
            base       = '0;
            errors     = 0;
        endfunction

        function void set_reg(input logic [INDEX_W-1:0] reg_index,
                              input logic [CFG_W-1:0] value);
            case (reg_index)
                REG_PIXEL_FORMAT:  fmt        = value[FMT_W-1:0];
                REG_RED_MASK:      red_mask   = value[WORD_W-1:0];
                REG_GREEN_MASK:    green_mask = value[WORD_W-1:0];
                REG_BLUE_MASK:     blue_mask  = value[WORD_W-1:0];
                REG_SCREEN_WIDTH:  width      = value[COORD_W-1:0];
                REG_SCREEN_HEIGHT: height     = value[COORD_W-1:0];
                REG_LINE_PITCH:    pitch      = value[COORD_W-1:0];
                REG_FRAME_BASE:    base       = value[FIELD_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [WORD_W-1:0] masked_channel(input logic [CHAN_W-1:0] level,
                                                   input logic [WORD_W-1:0] mask);
            int                lsb;
            logic [WORD_W-1:0] wide;
            lsb = 0;
            if (mask != '0)
                while (!mask[lsb])
                    lsb++;
            wide = {{(WORD_W - CHAN_W){1'b0}}, level};
            return (wide << lsb) & mask;
        endfunction

        function void note_pixel(input pixel_t px);
            logic [63:0] row;
            logic [63:0] col;
            logic [63:0] sum;
            result_t     w;
            if (px.pos_x >= width || px.pos_y >= height)
                return;
            row = 64'(px.pos_y);
            col = 64'(px.pos_x);
            sum = 64'(base) + ((row * 64'(pitch) + col) << 2);
            w.write_address = sum[FIELD_W-1:0];
            case (fmt)
                FMT_BGR:  w.pixel_word = {8'd0, px.red, px.green, px.blue};
                FMT_MASK: w.pixel_word = masked_channel(px.red, red_mask)
                                       | masked_channel(px.green, green_mask)
                                       | masked_channel(px.blue, blue_mask);
                default:  w.pixel_word = {8'd0, px.blue, px.green, px.red};
            endcase
            pending_writes.push_back(w);
        endfunction

        function void check_write(input result_t got);
            result_t want;
            if (pending_writes.size() == 0)
            begin
                $display("%0t: unexpected write, address %h word %h",
                         $time, got.write_address, got.pixel_word);
                errors++;
                return;
            end
            want = pending_writes.pop_front();
            if (got.write_address !== want.write_address)
            begin
                $display("%0t: write_address expected %h actual %h",
                         $time, want.write_address, got.write_address);
                errors++;
            end
            if (got.pixel_word !== want.pixel_word)
            begin
                $display("%0t: pixel_word expected %h actual %h",
                         $time, want.pixel_word, got.pixel_word);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [INDEX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    fb_write_tracker tracker = new();
    bit              tx_fast = 1'b0;
    bit              rx_fast = 1'b0;
    bit              long_hold_req = 1'b0;
    int              cycle_count = 0;

    framebuffer_pixel_writer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d writes outstanding",
                     $time, tracker.pending_writes.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 65)
            return 0;
        if (pick < 93)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic logic [CHAN_W-1:0] random_level();
        int pick;
        pick = $urandom_range(9, 0);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return CHAN_W'($urandom_range(255, 0));
    endfunction

    function automatic logic [WORD_W-1:0] random_mask();
        int pick;
        int lsb;
        pick = $urandom_range(6, 0);
        lsb  = $urandom_range(31, 0);
        case (pick)
            0:       return '0;
            1:       return '1;
            2:       return {24'd0, 8'hFF} << lsb;
            3:       return {27'd0, 5'h1F} << lsb;
            4:       return {31'd0, 1'b1} << lsb;
            default: return $urandom();
        endcase
    endfunction

    function automatic pixel_t make_pixel(input logic [COORD_W-1:0] x,
                                          input logic [COORD_W-1:0] y,
                                          input logic [CHAN_W-1:0] r,
                                          input logic [CHAN_W-1:0] g,
                                          input logic [CHAN_W-1:0] b);
        pixel_t px;
        px.pos_x = x;
        px.pos_y = y;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        return px;
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t px;
        int     pick;
        pick     = $urandom_range(99, 0);
        px.pos_x = COORD_W'($urandom_range(tracker.width - 16'd1, 0));
        px.pos_y = COORD_W'($urandom_range(tracker.height - 16'd1, 0));
        if (pick < 6)
            px.pos_x = COORD_W'($urandom_range(65535, tracker.width));
        else if (pick < 12)
            px.pos_y = COORD_W'($urandom_range(65535, tracker.height));
        else if (pick < 16)
            px.pos_x = tracker.width - 16'd1;
        else if (pick < 20)
            px.pos_y = tracker.height - 16'd1;
        px.red   = random_level();
        px.green = random_level();
        px.blue  = random_level();
        return px;
    endfunction

    task automatic write_reg(input logic [INDEX_W-1:0] reg_index,
                             input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.set_reg(reg_index, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic setup_frame(input logic [FMT_W-1:0] fmt,
                               input logic [WORD_W-1:0] rm,
                               input logic [WORD_W-1:0] gm,
                               input logic [WORD_W-1:0] bm,
                               input logic [COORD_W-1:0] w,
                               input logic [COORD_W-1:0] h,
                               input logic [COORD_W-1:0] p,
                               input logic [FIELD_W-1:0] b);
        write_reg(REG_PIXEL_FORMAT, CFG_W'(fmt));
        write_reg(REG_RED_MASK, CFG_W'(rm));
        write_reg(REG_GREEN_MASK, CFG_W'(gm));
        write_reg(REG_BLUE_MASK, CFG_W'(bm));
        write_reg(REG_SCREEN_WIDTH, CFG_W'(w));
        write_reg(REG_SCREEN_HEIGHT, CFG_W'(h));
        write_reg(REG_LINE_PITCH, CFG_W'(p));
        write_reg(REG_FRAME_BASE, CFG_W'(b));
    endtask

    task automatic random_setup();
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        logic [COORD_W-1:0] p;
        logic [FIELD_W-1:0] b;
        int                 pick;
        pick = $urandom_range(5, 0);
        case (pick)
            0:
            begin
                w = COORD_W'($urandom_range(64, 1));
                h = COORD_W'($urandom_range(64, 1));
            end
            1:
            begin
                w = '1;
                h = '1;
            end
            2:
            begin
                w = 16'd1;
                h = COORD_W'($urandom_range(65535, 1));
            end
            default:
            begin
                w = COORD_W'($urandom_range(65535, 1));
                h = COORD_W'($urandom_range(65535, 1));
            end
        endcase
        pick = $urandom_range(3, 0);
        case (pick)
            0:       p = '0;
            1:       p = '1;
            2:       p = w + COORD_W'($urandom_range(64, 0));
            default: p = COORD_W'($urandom_range(65535, 0));
        endcase
        pick = $urandom_range(3, 0);
        case (pick)
            0:       b = '0;
            1:       b = '1 - FIELD_W'($urandom_range(4095, 0));
            default: b = FIELD_W'({$urandom(), $urandom()});
        endcase
        setup_frame(FMT_W'($urandom_range(3, 0)), random_mask(), random_mask(),
                    random_mask(), w, h, p, b);
    endtask

    task automatic send_pixel(input pixel_t px);
        int gap;
        gap = tx_fast ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.note_pixel(px);
    endtask

    // hold the input idle until every pending write has come out
    task automatic drain_writes();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int stall_left;
        int hold_left;
        int gap;
        stall_left = 0;
        hold_left  = 0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_write(m_axis_tdata);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_fast)
                m_axis_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    stall_left = gap - 1;
                    m_axis_tready <= 1'b0;
                end
                else
                    m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        int     phase;
        int     shown;
        bit     paused;
        pixel_t px;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no screen size yet: everything drops
        send_pixel(make_pixel(16'd0, 16'd0, 8'h00, 8'h00, 8'h00));
        send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
        drain_writes();

        setup_frame(FMT_RGB, '0, '0, '0, 16'd640, 16'd480, 16'd1024, 48'h1000);
        send_pixel(make_pixel(16'd0, 16'd0, 8'h00, 8'h00, 8'h00));
        send_pixel(make_pixel(16'd639, 16'd479, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(16'd640, 16'd0, 8'h12, 8'h34, 8'h56));
        send_pixel(make_pixel(16'd0, 16'd480, 8'h12, 8'h34, 8'h56));
        send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(16'd1, 16'd1, 8'hA5, 8'h5A, 8'h3C));
        drain_writes();

        setup_frame(FMT_BGR, '0, '0, '0, 16'd640, 16'd480, 16'd1024, 48'h1000);
        send_pixel(make_pixel(16'd5, 16'd7, 8'h12, 8'h34, 8'h56));
        send_pixel(make_pixel(16'd639, 16'd0, 8'hFF, 8'h00, 8'h80));
        drain_writes();

        setup_frame(FMT_SPARE, '0, '0, '0, 16'd640, 16'd480, 16'd1024, 48'h1000);
        send_pixel(make_pixel(16'd2, 16'd3, 8'h11, 8'h22, 8'h33));
        drain_writes();

        setup_frame(FMT_MASK, 32'h0000_F800, 32'h0000_07E0, 32'h0000_001F,
                    16'd320, 16'd240, 16'd320, 48'h8000_0000);
        send_pixel(make_pixel(16'd10, 16'd20, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(16'd319, 16'd239, 8'hA5, 8'h3C, 8'h81));
        drain_writes();

        // zero mask, top bit only, and full mask
        setup_frame(FMT_MASK, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                    16'd1, 16'd1, 16'd0, 48'h0);
        send_pixel(make_pixel(16'd0, 16'd0, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(16'd0, 16'd0, 8'h5A, 8'hFE, 8'hC3));
        send_pixel(make_pixel(16'd1, 16'd0, 8'hFF, 8'hFF, 8'hFF));
        drain_writes();

        // address wraps past the top of the address space
        setup_frame(FMT_RGB, '0, '0, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    48'hFFFF_FFFF_FFF0);
        send_pixel(make_pixel(16'hFFFE, 16'hFFFE, 8'h01, 8'h02, 8'h03));
        send_pixel(make_pixel(16'd0, 16'd0, 8'hFF, 8'h00, 8'hFF));
        send_pixel(make_pixel(16'hFFFE, 16'd0, 8'h00, 8'hFF, 8'h00));
        send_pixel(make_pixel(16'hFFFF, 16'd0, 8'h00, 8'hFF, 8'h00));
        drain_writes();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            random_setup();
            tx_fast = ($urandom_range(3, 0) == 0);
            rx_fast = ($urandom_range(3, 0) == 0);
            if (phase == 2)
            begin
                tx_fast       = 1'b1;
                rx_fast       = 1'b0;
                long_hold_req = 1'b1;
            end
            shown  = 0;
            paused = 1'b0;
            while (shown < WRITES_PER_PHASE)
            begin
                px = random_pixel();
                if (px.pos_x < tracker.width && px.pos_y < tracker.height)
                    shown++;
                send_pixel(px);
                if (phase == 5 && !paused && shown >= WRITES_PER_PHASE / 2)
                begin
                    paused = 1'b1;
                    drain_writes();
                end
            end
            drain_writes();
        end

        if (tracker.errors == 0 && tracker.pending_writes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
